@@ sv/owbm_pkg.sv @@
package owbm_pkg;

	// Command codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_RESET = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_TAIL = 3'd3,
		PH_SLOT_LOW = 3'd4,
		PH_SLOT_REL = 3'd5
	} phase_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_RESET_LOW     = 3'd0,
		REG_PRESENCE_WAIT = 3'd1,
		REG_RESET_TAIL    = 3'd2,
		REG_SHORT_LOW     = 3'd3,
		REG_SLOT          = 3'd4
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int LONG_W     = 9;
	localparam int SHORT_W    = 4;
	localparam int SLOT_W     = 7;

	localparam logic [LONG_W-1:0]  RESET_LOW_DEF     = 9'd480;
	localparam logic [LONG_W-1:0]  PRESENCE_WAIT_DEF = 9'd80;
	localparam logic [LONG_W-1:0]  RESET_TAIL_DEF    = 9'd400;
	localparam logic [SHORT_W-1:0] SHORT_LOW_DEF     = 4'd1;
	localparam logic [SLOT_W-1:0]  SLOT_DEF          = 7'd50;

	// One result item
	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence;
		logic [7:0] read_byte;
	} res_t;

endpackage

@@ sv/owbm_cmd_if.sv @@
interface owbm_cmd_if;
	logic       valid;
	logic       ready;
	logic       start_req;
	logic [1:0] mode;
	logic [7:0] write_byte;
	logic       line_level;

	modport source (output valid, output start_req, output mode, output write_byte,
		output line_level, input ready);
	modport sink (input valid, input start_req, input mode, input write_byte,
		input line_level, output ready);
endinterface

@@ sv/owbm_res_if.sv @@
interface owbm_res_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic       presence;
	logic [7:0] read_byte;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output presence, output read_byte, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input presence, input read_byte, output ready);
endinterface

@@ sv/onewire_bus_master.sv @@
// 1-Wire bus master, stepped by one item per microsecond tick.
// cmd channel: each transfer is one tick carrying start_req, mode (reset and
//   presence, write byte, read byte), write_byte and the sampled line_level.
//   A request is taken only while the master is idle; mode 3 is ignored.
// res channel: exactly one result per tick: drive_low for the bus pin,
//   busy_res, done_res on the last tick of a command, presence from the last
//   reset and read_byte from the last completed read.
// Output: the result of a tick is registered and presented in the cycle after its transfer.
// Throughput: one tick per cycle while cmd.ready is high; the next sequencer state and
//   tick counter are computed combinationally from the registered state and the tick's payload.
// Stall: the result register holds a pending result while res.ready is low; cmd.ready stays
//   high while that register is empty or being drained in the same cycle.
// Configuration: five timing registers on cfg_we/cfg_index/cfg_data; the user must write
//   them only while no command runs, which the block does not enforce. A zero duration
//   counts as one tick, and a duration above 2^COUNT_BITS-1 is cut to that value.
// Reset (arst_n low): the sequencer goes idle, presence and read_byte clear,
//   timing registers return to their defaults, no result is pending.
module onewire_bus_master #(
	parameter int COUNT_BITS = 9
) (
	input  logic                              clk,
	input  logic                              arst_n,
	owbm_cmd_if.sink                          cmd,
	owbm_res_if.source                        res,
	input  logic                              cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owbm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int LW = (COUNT_BITS > owbm_pkg::LONG_W) ? COUNT_BITS : owbm_pkg::LONG_W;
	localparam logic [LW-1:0] CAP = LW'((1 << COUNT_BITS) - 1);
	localparam logic [LW-1:0] ONE = LW'(1);

	// Clamp a duration to the range 1 .. CAP
	function automatic logic [LW-1:0] span(input logic [LW-1:0] v);
		logic [LW-1:0] r;
		r = v;
		if (v == '0) r = ONE;
		if (v > CAP) r = CAP;
		return r;
	endfunction

	// Timing registers
	logic [owbm_pkg::LONG_W-1:0]  reset_low_q;
	logic [owbm_pkg::LONG_W-1:0]  presence_wait_q;
	logic [owbm_pkg::LONG_W-1:0]  reset_tail_q;
	logic [owbm_pkg::SHORT_W-1:0] short_low_q;
	logic [owbm_pkg::SLOT_W-1:0]  slot_q;

	// Sequencer state
	owbm_pkg::phase_t        phase_q, phase_d;
	logic [COUNT_BITS-1:0]   tick_q, tick_d;
	logic [2:0]              bit_q, bit_d;
	logic [7:0]              shift_q, shift_d;
	owbm_pkg::mode_t         amode_q, amode_d;
	logic                    pres_q, pres_d;
	logic [7:0]              last_read_q, last_read_d;
	logic                    drive_d, done_d;

	// Result register
	logic                    res_valid_q;
	owbm_pkg::res_t          res_q;

	logic acc;
	logic [LW-1:0]         len;
	logic [COUNT_BITS-1:0] tick_inc;
	logic                  zero_slot;

	assign cmd.ready = !res_valid_q || res.ready;
	assign acc       = cmd.valid && cmd.ready;

	// Write timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= owbm_pkg::RESET_LOW_DEF;
			presence_wait_q <= owbm_pkg::PRESENCE_WAIT_DEF;
			reset_tail_q    <= owbm_pkg::RESET_TAIL_DEF;
			short_low_q     <= owbm_pkg::SHORT_LOW_DEF;
			slot_q          <= owbm_pkg::SLOT_DEF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				owbm_pkg::REG_RESET_LOW:     reset_low_q     <= cfg_data[owbm_pkg::LONG_W-1:0];
				owbm_pkg::REG_PRESENCE_WAIT: presence_wait_q <= cfg_data[owbm_pkg::LONG_W-1:0];
				owbm_pkg::REG_RESET_TAIL:    reset_tail_q    <= cfg_data[owbm_pkg::LONG_W-1:0];
				owbm_pkg::REG_SHORT_LOW:     short_low_q     <= cfg_data[owbm_pkg::SHORT_W-1:0];
				owbm_pkg::REG_SLOT:          slot_q          <= cfg_data[owbm_pkg::SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the sequencer by one tick
	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		amode_d     = amode_q;
		pres_d      = pres_q;
		last_read_d = last_read_q;
		drive_d     = 1'b0;
		done_d      = 1'b0;
		len         = ONE;
		zero_slot   = 1'b0;
		tick_inc    = '0;

		// Take a new command when idle
		if (phase_q == owbm_pkg::PH_IDLE && cmd.start_req
				&& owbm_pkg::mode_t'(cmd.mode) != owbm_pkg::MODE_NONE) begin
			amode_d = owbm_pkg::mode_t'(cmd.mode);
			shift_d = (amode_d == owbm_pkg::MODE_WRITE) ? cmd.write_byte : 8'd0;
			bit_d   = 3'd0;
			tick_d  = '0;
			phase_d = (amode_d == owbm_pkg::MODE_RESET) ? owbm_pkg::PH_RST_LOW
				: owbm_pkg::PH_SLOT_LOW;
		end

		if (phase_d != owbm_pkg::PH_IDLE) begin
			zero_slot = (amode_d == owbm_pkg::MODE_WRITE) && !shift_d[bit_d];
			unique case (phase_d)
				owbm_pkg::PH_RST_LOW: begin
					len     = span(LW'(reset_low_q));
					drive_d = 1'b1;
				end
				owbm_pkg::PH_RST_WAIT: len = span(LW'(presence_wait_q));
				owbm_pkg::PH_RST_TAIL: len = span(LW'(reset_tail_q));
				owbm_pkg::PH_SLOT_LOW: begin
					drive_d = 1'b1;
					len     = zero_slot ? span(LW'(slot_q)) : span(LW'(short_low_q));
				end
				default: begin
					len = zero_slot ? span(LW'(short_low_q)) : span(LW'(slot_q));
					// Sample the read bit on the first released tick
					if (amode_d == owbm_pkg::MODE_READ && tick_d == '0 && cmd.line_level)
						shift_d[bit_d] = 1'b1;
				end
			endcase

			tick_inc = tick_d + 1'b1;
			if (LW'(tick_inc) >= len) begin
				tick_d = '0;
				unique case (phase_d)
					owbm_pkg::PH_RST_LOW: phase_d = owbm_pkg::PH_RST_WAIT;
					owbm_pkg::PH_RST_WAIT: begin
						pres_d  = !cmd.line_level;
						phase_d = owbm_pkg::PH_RST_TAIL;
					end
					owbm_pkg::PH_RST_TAIL: begin
						phase_d = owbm_pkg::PH_IDLE;
						done_d  = 1'b1;
					end
					owbm_pkg::PH_SLOT_LOW: phase_d = owbm_pkg::PH_SLOT_REL;
					default: begin
						if (bit_d == 3'd7) begin
							if (amode_d == owbm_pkg::MODE_READ) last_read_d = shift_d;
							phase_d = owbm_pkg::PH_IDLE;
							done_d  = 1'b1;
							bit_d   = 3'd0;
						end else begin
							bit_d   = bit_d + 3'd1;
							phase_d = owbm_pkg::PH_SLOT_LOW;
						end
					end
				endcase
			end else begin
				tick_d = tick_inc;
			end
		end
	end

	// Hold sequencer state; update on each tick transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= owbm_pkg::PH_IDLE;
			tick_q      <= '0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			amode_q     <= owbm_pkg::MODE_RESET;
			pres_q      <= 1'b0;
			last_read_q <= 8'd0;
		end else if (acc) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			amode_q     <= amode_d;
			pres_q      <= pres_d;
			last_read_q <= last_read_d;
		end
	end

	// Result valid: set on transfer in, drop on transfer out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			res_q.drive_low <= drive_d;
			res_q.busy_res  <= (phase_d != owbm_pkg::PH_IDLE);
			res_q.done_res  <= done_d;
			res_q.presence  <= pres_d;
			res_q.read_byte <= last_read_d;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = res_q.drive_low;
	assign res.busy_res  = res_q.busy_res;
	assign res.done_res  = res_q.done_res;
	assign res.presence  = res_q.presence;
	assign res.read_byte = res_q.read_byte;

`ifndef SYNTHESIS
	// Every accepted tick yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res.valid)
		else $error("tick accepted without a result");

	// An idle tick with no request reports not busy
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == owbm_pkg::PH_IDLE && !cmd.start_req) |=> !res.busy_res)
		else $error("busy reported on an idle tick");

	// The reset pulse always pulls the bus low
	a_reset_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && phase_q == owbm_pkg::PH_RST_LOW) |=> res.drive_low)
		else $error("bus released during reset pulse");

	// A finishing command leaves the master idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && done_d) |=> (phase_q == owbm_pkg::PH_IDLE && res.done_res && !res.busy_res))
		else $error("done without returning to idle");
`endif

endmodule

@@ tb/owbm_checker.sv @@
module owbm_checker import owbm_pkg::*; #(
	parameter int COUNT_BITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	owbm_cmd_if                   cmd,
	owbm_res_if                   res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

	// timing registers as the master holds them
	logic [LONG_W-1:0]  rst_low_len, pres_wait_len, rst_tail_len;
	logic [SHORT_W-1:0] short_len;
	logic [SLOT_W-1:0]  slot_len;

	// sequencer state of the predicted master
	phase_t                seq_ph;
	logic [COUNT_BITS-1:0] tick_cnt;
	logic [2:0]            bit_pos;
	logic [7:0]            shift_reg;
	mode_t                 cur_mode;
	logic                  pres_flag;
	logic [7:0]            last_byte;

	// predicted bus results, oldest first
	res_t bus_res_q[$];
	int   n_bad;

	// clamp a register value to a usable tick count
	function automatic int ticks_of(input int v);
		if (v == 0)
			return 1;
		if (v > COUNT_MAX)
			return COUNT_MAX;
		return v;
	endfunction

	// advance the master by one tick and produce its bus result
	task automatic tick_model(input logic start, input logic [1:0] mode_bits,
			input logic [7:0] wb, input logic line, output res_t r);
		int    len;
		logic  drv, fin, zero_slot;
		mode_t md;
		md  = mode_t'(mode_bits);
		drv = 1'b0;
		fin = 1'b0;
		len = 1;

		// take a new command only while idle
		if (seq_ph == PH_IDLE && start && md != MODE_NONE) begin
			cur_mode  = md;
			shift_reg = (md == MODE_WRITE) ? wb : 8'h00;
			bit_pos   = 3'd0;
			tick_cnt  = '0;
			seq_ph    = (md == MODE_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
		end

		if (seq_ph != PH_IDLE) begin
			zero_slot = (cur_mode == MODE_WRITE) && !shift_reg[bit_pos];
			case (seq_ph)
				PH_RST_LOW: begin
					len = ticks_of(int'(rst_low_len));
					drv = 1'b1;
				end
				PH_RST_WAIT: len = ticks_of(int'(pres_wait_len));
				PH_RST_TAIL: len = ticks_of(int'(rst_tail_len));
				PH_SLOT_LOW: begin
					drv = 1'b1;
					len = ticks_of(zero_slot ? int'(slot_len) : int'(short_len));
				end
				default: begin
					len = ticks_of(zero_slot ? int'(short_len) : int'(slot_len));
					// sample the read bit on the first released tick
					if (cur_mode == MODE_READ && tick_cnt == '0 && line)
						shift_reg[bit_pos] = 1'b1;
				end
			endcase

			tick_cnt = tick_cnt + 1'b1;
			if (int'(tick_cnt) >= len) begin
				tick_cnt = '0;
				case (seq_ph)
					PH_RST_LOW:  seq_ph = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_flag = !line;
						seq_ph    = PH_RST_TAIL;
					end
					PH_RST_TAIL: begin
						seq_ph = PH_IDLE;
						fin    = 1'b1;
					end
					PH_SLOT_LOW: seq_ph = PH_SLOT_REL;
					default: begin
						if (bit_pos == 3'd7) begin
							if (cur_mode == MODE_READ)
								last_byte = shift_reg;
							seq_ph  = PH_IDLE;
							fin     = 1'b1;
							bit_pos = 3'd0;
						end else begin
							bit_pos = bit_pos + 1'b1;
							seq_ph  = PH_SLOT_LOW;
						end
					end
				endcase
			end
		end

		r.drive_low = drv;
		r.busy_res  = (seq_ph != PH_IDLE);
		r.done_res  = fin;
		r.presence  = pres_flag;
		r.read_byte = last_byte;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t got, want, pred;
		if (!arst_n) begin
			rst_low_len   = RESET_LOW_DEF;
			pres_wait_len = PRESENCE_WAIT_DEF;
			rst_tail_len  = RESET_TAIL_DEF;
			short_len     = SHORT_LOW_DEF;
			slot_len      = SLOT_DEF;
			seq_ph        = PH_IDLE;
			tick_cnt      = '0;
			bit_pos       = 3'd0;
			shift_reg     = 8'h00;
			cur_mode      = MODE_RESET;
			pres_flag     = 1'b0;
			last_byte     = 8'h00;
			bus_res_q.delete();
		end else begin
			// compare a result transfer with the oldest prediction
			if (res.valid && res.ready) begin
				got.drive_low = res.drive_low;
				got.busy_res  = res.busy_res;
				got.done_res  = res.done_res;
				got.presence  = res.presence;
				got.read_byte = res.read_byte;
				if (bus_res_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("%0t: unexpected result",
							" drive=%0b busy=%0b done=%0b pres=%0b rd=%02h",
							$time, got.drive_low, got.busy_res, got.done_res,
							got.presence, got.read_byte);
				end else begin
					want = bus_res_q.pop_front();
					if (got.drive_low !== want.drive_low || got.busy_res !== want.busy_res ||
							got.done_res !== want.done_res || got.presence !== want.presence ||
							got.read_byte !== want.read_byte) begin
						n_bad++;
						if (n_bad <= 10)
							$display("%0t: result mismatch exp drive=%0b busy=%0b",
								$time, want.drive_low, want.busy_res,
								" done=%0b pres=%0b rd=%02h,",
								want.done_res, want.presence, want.read_byte,
								" got drive=%0b busy=%0b",
								got.drive_low, got.busy_res,
								" done=%0b pres=%0b rd=%02h",
								got.done_res, got.presence, got.read_byte);
					end
				end
			end

			// mirror register writes, masked to each register's width
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_RESET_LOW:     rst_low_len   = cfg_data[LONG_W-1:0];
					REG_PRESENCE_WAIT: pres_wait_len = cfg_data[LONG_W-1:0];
					REG_RESET_TAIL:    rst_tail_len  = cfg_data[LONG_W-1:0];
					REG_SHORT_LOW:     short_len     = cfg_data[SHORT_W-1:0];
					REG_SLOT:          slot_len      = cfg_data[SLOT_W-1:0];
					default: ;
				endcase
			end

			// predict the result of each tick transfer
			if (cmd.valid && cmd.ready) begin
				tick_model(cmd.start_req, cmd.mode, cmd.write_byte, cmd.line_level, pred);
				bus_res_q.push_back(pred);
			end
		end
		mismatches  <= n_bad;
		outstanding <= bus_res_q.size();
	end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import owbm_pkg::*;

	localparam int COUNT_BITS = 9;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    outstanding;
	logic                  last_busy;
	logic                  long_hold_req;
	int                    burst_left;

	owbm_cmd_if cmd_ch ();
	owbm_res_if res_ch ();

	onewire_bus_master #(
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	owbm_checker #(
		.COUNT_BITS(COUNT_BITS)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.res         (res_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hold the busy flag of the last result taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			last_busy <= 1'b0;
		else if (res_ch.valid && res_ch.ready)
			last_busy <= res_ch.busy_res;
	end

	// end a hung run
	initial begin
		#15_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: switch between stall patterns, with one long hold-off
	initial begin : res_drain
		int   pat, span_len;
		logic held;
		held = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (150) @(posedge clk);
			end
			pat      = $urandom_range(0, 5);
			span_len = (pat == 5) ? $urandom_range(1, 12) : $urandom_range(4, 40);
			repeat (span_len) begin
				case (pat)
					0, 1:    res_ch.ready <= 1'b1;
					2:       res_ch.ready <= 1'($urandom_range(0, 1));
					3, 4:    res_ch.ready <= ($urandom_range(0, 4) != 0);
					default: res_ch.ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	// offer one tick and wait for its transfer; idle between bursts
	task automatic send_tick(input logic start, input mode_t md, input logic [7:0] wb,
			input logic line);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		burst_left--;
		cmd_ch.valid      <= 1'b1;
		cmd_ch.start_req  <= start;
		cmd_ch.mode       <= md;
		cmd_ch.write_byte <= wb;
		cmd_ch.line_level <= line;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
	endtask

	// random tick; no requests when only running out a command
	task automatic rand_tick(input logic no_request);
		int         pick;
		logic       start;
		mode_t      md;
		logic [7:0] wb;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1, 2: md = MODE_RESET;
			3, 4, 5: md = MODE_WRITE;
			6, 7, 8: md = MODE_READ;
			default: md = MODE_NONE;
		endcase
		case ($urandom_range(0, 7))
			0:       wb = 8'h00;
			1:       wb = 8'hFF;
			default: wb = 8'($urandom);
		endcase
		start = no_request ? 1'b0 : ($urandom_range(0, 4) != 0);
		send_tick(start, md, wb, 1'($urandom_range(0, 1)));
	endtask

	// drain all results and run out any command still in progress
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		forever begin
			do
				@(posedge clk);
			while (outstanding != 0);
			if (!last_busy)
				break;
			repeat (16) rand_tick(1'b1);
			cmd_ch.valid <= 1'b0;
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic write_timing(input int rst_low, input int pres_wait, input int rst_tail,
			input int short_low, input int slot);
		write_reg(REG_RESET_LOW, rst_low);
		write_reg(REG_PRESENCE_WAIT, pres_wait);
		write_reg(REG_RESET_TAIL, rst_tail);
		write_reg(REG_SHORT_LOW, short_low);
		write_reg(REG_SLOT, slot);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_RESET_LOW;
		cfg_data          = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.start_req  = 1'b0;
		cmd_ch.mode       = MODE_RESET;
		cmd_ch.write_byte = 8'h00;
		cmd_ch.line_level = 1'b1;
		long_hold_req     = 1'b0;
		burst_left        = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero durations count as one tick, so every phase is one tick here
		write_timing(0, 0, 0, 0, 0);

		// reset with a device pulling the bus low at the sample
		send_tick(1'b1, MODE_RESET, 8'h00, 1'b1);
		send_tick(1'b0, MODE_RESET, 8'h00, 1'b0);
		send_tick(1'b0, MODE_RESET, 8'h00, 1'b1);
		// reset with nobody answering
		send_tick(1'b1, MODE_RESET, 8'hFF, 1'b1);
		repeat (2) send_tick(1'b0, MODE_RESET, 8'hFF, 1'b1);
		// unknown mode leaves the master idle
		send_tick(1'b1, MODE_NONE, 8'hFF, 1'b0);
		// write byte, with requests arriving while busy
		send_tick(1'b1, MODE_WRITE, 8'hA5, 1'b1);
		repeat (15) send_tick(1'b1, MODE_READ, 8'h5A, 1'b0);
		// read byte with the bus high on every sample
		send_tick(1'b1, MODE_READ, 8'h00, 1'b1);
		repeat (15) send_tick(1'b0, MODE_READ, 8'h00, 1'b1);
		settle();

		// random commands over short timings, minimum first
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 0)
				write_timing(1, 1, 1, 1, 1);
			else
				write_timing($urandom_range(1, 8 + ph * 20), $urandom_range(1, 8 + ph * 20),
					$urandom_range(1, 8 + ph * 20), $urandom_range(1, 15),
					$urandom_range(1, 4 + ph * 10));
			if (ph == 1)
				long_hold_req <= 1'b1;
			repeat (150) rand_tick(1'b0);
			settle();
		end

		// longest reset pulse, with the slot registers at their maximum
		write_timing(511, 1, 1, 15, 127);
		send_tick(1'b1, MODE_RESET, 8'h00, 1'b0);
		settle();

		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
